>>> rtl/park_pkg.sv
`timescale 1ns / 1ps

package park_pkg;

  // Quarter-wave sine table: 65 entries, magnitudes up to 32767.
  localparam int TAB_W      = 15;
  localparam int TAB_IDX_W  = 7;
  // Largest step between neighbouring entries is 804.
  localparam int DELTA_W    = 10;
  // Signed sine and cosine, Q1.15.
  localparam int TRIG_W     = 16;
  // Sums carry 15 fraction bits; half an output step is added before the cut.
  localparam int ROUND_POS  = 15;
  localparam int ROUND_HALF = 16384;

  function automatic logic [TAB_W-1:0] quarter_sine(input logic [TAB_IDX_W-1:0] idx);
    logic [TAB_W-1:0] val;
    unique case (idx)
      7'd0:  val = 15'd0;
      7'd1:  val = 15'd804;
      7'd2:  val = 15'd1608;
      7'd3:  val = 15'd2410;
      7'd4:  val = 15'd3212;
      7'd5:  val = 15'd4011;
      7'd6:  val = 15'd4808;
      7'd7:  val = 15'd5602;
      7'd8:  val = 15'd6393;
      7'd9:  val = 15'd7179;
      7'd10: val = 15'd7962;
      7'd11: val = 15'd8739;
      7'd12: val = 15'd9512;
      7'd13: val = 15'd10278;
      7'd14: val = 15'd11039;
      7'd15: val = 15'd11793;
      7'd16: val = 15'd12539;
      7'd17: val = 15'd13279;
      7'd18: val = 15'd14010;
      7'd19: val = 15'd14732;
      7'd20: val = 15'd15446;
      7'd21: val = 15'd16151;
      7'd22: val = 15'd16846;
      7'd23: val = 15'd17530;
      7'd24: val = 15'd18204;
      7'd25: val = 15'd18868;
      7'd26: val = 15'd19519;
      7'd27: val = 15'd20159;
      7'd28: val = 15'd20787;
      7'd29: val = 15'd21403;
      7'd30: val = 15'd22005;
      7'd31: val = 15'd22594;
      7'd32: val = 15'd23170;
      7'd33: val = 15'd23731;
      7'd34: val = 15'd24279;
      7'd35: val = 15'd24811;
      7'd36: val = 15'd25329;
      7'd37: val = 15'd25832;
      7'd38: val = 15'd26319;
      7'd39: val = 15'd26790;
      7'd40: val = 15'd27245;
      7'd41: val = 15'd27683;
      7'd42: val = 15'd28105;
      7'd43: val = 15'd28510;
      7'd44: val = 15'd28898;
      7'd45: val = 15'd29268;
      7'd46: val = 15'd29621;
      7'd47: val = 15'd29956;
      7'd48: val = 15'd30273;
      7'd49: val = 15'd30571;
      7'd50: val = 15'd30852;
      7'd51: val = 15'd31113;
      7'd52: val = 15'd31356;
      7'd53: val = 15'd31580;
      7'd54: val = 15'd31785;
      7'd55: val = 15'd31971;
      7'd56: val = 15'd32137;
      7'd57: val = 15'd32285;
      7'd58: val = 15'd32412;
      7'd59: val = 15'd32521;
      7'd60: val = 15'd32609;
      7'd61: val = 15'd32678;
      7'd62: val = 15'd32728;
      7'd63: val = 15'd32757;
      // The peak entry; indexes past it only occur as the unused upper neighbour.
      default: val = 15'd32767;
    endcase
    return val;
  endfunction

endpackage

>>> rtl/park_sincos.sv
`timescale 1ns / 1ps

module park_sincos #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int PHASE_WIDTH  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   up_valid,
  output logic                                   up_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]         up_alpha,
  input  logic signed [SAMPLE_WIDTH-1:0]         up_beta,
  input  logic        [PHASE_WIDTH-1:0]          up_phase,
  output logic                                   dn_valid,
  input  logic                                   dn_ready,
  output logic signed [SAMPLE_WIDTH-1:0]         dn_alpha,
  output logic signed [SAMPLE_WIDTH-1:0]         dn_beta,
  output logic signed [park_pkg::TRIG_W-1:0]     dn_sin,
  output logic signed [park_pkg::TRIG_W-1:0]     dn_cos
);

  localparam int FRAC_W = PHASE_WIDTH - 8;
  localparam int FW     = (FRAC_W == 0) ? 1 : FRAC_W;
  localparam int P_W    = PHASE_WIDTH - 2;
  localparam int PROD_W = park_pkg::DELTA_W + FW + 1;
  localparam logic [P_W:0]    QUARTER = (P_W + 1)'(1) << P_W;
  localparam logic [FW-1:0]   FMASK   = (FRAC_W == 0) ? '0 : '1;
  localparam logic [PROD_W-1:0] HALF  = (FRAC_W == 0) ? '0 : (PROD_W'(1) << (FW - 1));

  // Stage A: quadrant folding and table reads.
  logic                              valid_a_r;
  logic                              ready_a;
  logic signed [SAMPLE_WIDTH-1:0]    alpha_a_r, beta_a_r;
  logic [park_pkg::TAB_W-1:0]        sin_base_r, cos_base_r;
  logic [park_pkg::DELTA_W-1:0]      sin_delta_r, cos_delta_r;
  logic [FW-1:0]                     sin_frac_r, cos_frac_r;
  logic                              sin_neg_r, cos_neg_r;

  logic [1:0]                        sin_quad, cos_quad;
  logic [P_W:0]                      v_direct, v_mirror, sin_v, cos_v;
  logic [park_pkg::TAB_IDX_W-1:0]    sin_idx, cos_idx;
  logic [park_pkg::TAB_W-1:0]        sin_base_nxt, cos_base_nxt;
  logic [park_pkg::TAB_W-1:0]        sin_next, cos_next;

  // Stage B: interpolation and sign.
  logic                              valid_b_r;
  logic                              ready_b;
  logic signed [SAMPLE_WIDTH-1:0]    alpha_b_r, beta_b_r;
  logic signed [park_pkg::TRIG_W-1:0] sin_r, cos_r;
  logic signed [park_pkg::TRIG_W-1:0] sin_nxt, cos_nxt;

  function automatic logic signed [park_pkg::TRIG_W-1:0] interp(
    input logic [park_pkg::TAB_W-1:0]   base,
    input logic [park_pkg::DELTA_W-1:0] delta,
    input logic [FW-1:0]                frac,
    input logic                         neg
  );
    logic [PROD_W-1:0]          prod;
    logic [park_pkg::TAB_W-1:0] mag;
    prod = PROD_W'(delta) * PROD_W'(frac) + HALF;
    prod = prod >> FRAC_W;
    mag  = base + prod[park_pkg::TAB_W-1:0];
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  assign ready_a  = !valid_a_r || ready_b;
  assign ready_b  = !valid_b_r || dn_ready;
  assign up_ready = ready_a;

  // Cosine is the sine one quadrant on, so both share the fold of the low bits.
  always_comb begin
    sin_quad     = up_phase[PHASE_WIDTH-1 -: 2];
    cos_quad     = sin_quad + 2'd1;
    v_direct     = {1'b0, up_phase[P_W-1:0]};
    v_mirror     = QUARTER - v_direct;
    sin_v        = sin_quad[0] ? v_mirror : v_direct;
    cos_v        = cos_quad[0] ? v_mirror : v_direct;
    sin_idx      = sin_v[P_W:FRAC_W];
    cos_idx      = cos_v[P_W:FRAC_W];
    sin_base_nxt = park_pkg::quarter_sine(sin_idx);
    cos_base_nxt = park_pkg::quarter_sine(cos_idx);
    sin_next     = park_pkg::quarter_sine(sin_idx + 7'd1);
    cos_next     = park_pkg::quarter_sine(cos_idx + 7'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else if (ready_a) begin
      valid_a_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && up_valid) begin
      alpha_a_r   <= up_alpha;
      beta_a_r    <= up_beta;
      sin_base_r  <= sin_base_nxt;
      cos_base_r  <= cos_base_nxt;
      sin_delta_r <= park_pkg::DELTA_W'(sin_next - sin_base_nxt);
      cos_delta_r <= park_pkg::DELTA_W'(cos_next - cos_base_nxt);
      sin_frac_r  <= FW'(sin_v) & FMASK;
      cos_frac_r  <= FW'(cos_v) & FMASK;
      sin_neg_r   <= sin_quad[1];
      cos_neg_r   <= cos_quad[1];
    end
  end

  always_comb begin
    sin_nxt = interp(sin_base_r, sin_delta_r, sin_frac_r, sin_neg_r);
    cos_nxt = interp(cos_base_r, cos_delta_r, cos_frac_r, cos_neg_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
    end else if (ready_b) begin
      valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b && valid_a_r) begin
      alpha_b_r <= alpha_a_r;
      beta_b_r  <= beta_a_r;
      sin_r     <= sin_nxt;
      cos_r     <= cos_nxt;
    end
  end

  assign dn_valid = valid_b_r;
  assign dn_alpha = alpha_b_r;
  assign dn_beta  = beta_b_r;
  assign dn_sin   = sin_r;
  assign dn_cos   = cos_r;

`ifndef SYNTHESIS
  // The table peaks at 32767, so the most negative code can never appear.
  a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_b_r |-> (sin_r != {1'b1, {(park_pkg::TRIG_W-1){1'b0}}}) &&
                  (cos_r != {1'b1, {(park_pkg::TRIG_W-1){1'b0}}}))
    else $error("sine or cosine out of range");
`endif

endmodule

>>> rtl/park_mult.sv
`timescale 1ns / 1ps

module park_mult #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              up_valid,
  output logic                                              up_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]                    up_alpha,
  input  logic signed [SAMPLE_WIDTH-1:0]                    up_beta,
  input  logic signed [park_pkg::TRIG_W-1:0]                up_sin,
  input  logic signed [park_pkg::TRIG_W-1:0]                up_cos,
  output logic                                              dn_valid,
  input  logic                                              dn_ready,
  output logic signed [SAMPLE_WIDTH+park_pkg::TRIG_W-1:0]   dn_ac,
  output logic signed [SAMPLE_WIDTH+park_pkg::TRIG_W-1:0]   dn_bs,
  output logic signed [SAMPLE_WIDTH+park_pkg::TRIG_W-1:0]   dn_bc,
  output logic signed [SAMPLE_WIDTH+park_pkg::TRIG_W-1:0]   dn_as
);

  localparam int PROD_W = SAMPLE_WIDTH + park_pkg::TRIG_W;

  logic                     valid_c_r;
  logic                     ready_c;
  logic signed [PROD_W-1:0] prod_ac_r, prod_bs_r, prod_bc_r, prod_as_r;

  assign ready_c  = !valid_c_r || dn_ready;
  assign up_ready = ready_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_c_r <= 1'b0;
    end else if (ready_c) begin
      valid_c_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_c && up_valid) begin
      prod_ac_r <= up_alpha * up_cos;
      prod_bs_r <= up_beta * up_sin;
      prod_bc_r <= up_beta * up_cos;
      prod_as_r <= up_alpha * up_sin;
    end
  end

  assign dn_valid = valid_c_r;
  assign dn_ac    = prod_ac_r;
  assign dn_bs    = prod_bs_r;
  assign dn_bc    = prod_bc_r;
  assign dn_as    = prod_as_r;

`ifndef SYNTHESIS
  // A product held back by the rounding stage must survive until it is taken.
  a_hold_products: assert property (@(posedge clk) disable iff (!rst_n)
    valid_c_r && !dn_ready |=> valid_c_r && $stable(prod_ac_r) && $stable(prod_bs_r) &&
                               $stable(prod_bc_r) && $stable(prod_as_r))
    else $error("stalled products changed");
`endif

endmodule

>>> rtl/park_round.sv
`timescale 1ns / 1ps

module park_round #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              up_valid,
  output logic                                              up_ready,
  input  logic signed [SAMPLE_WIDTH+park_pkg::TRIG_W-1:0]   up_ac,
  input  logic signed [SAMPLE_WIDTH+park_pkg::TRIG_W-1:0]   up_bs,
  input  logic signed [SAMPLE_WIDTH+park_pkg::TRIG_W-1:0]   up_bc,
  input  logic signed [SAMPLE_WIDTH+park_pkg::TRIG_W-1:0]   up_as,
  output logic                                              dn_valid,
  input  logic                                              dn_ready,
  output logic signed [SAMPLE_WIDTH:0]                      dn_direct,
  output logic signed [SAMPLE_WIDTH:0]                      dn_quadrature
);

  localparam int SUM_W = SAMPLE_WIDTH + park_pkg::TRIG_W + 1;

  logic                       valid_d_r;
  logic                       ready_d;
  logic signed [SAMPLE_WIDTH:0] direct_r, quadrature_r;
  logic signed [SUM_W-1:0]    d_sum, q_sum;

  assign ready_d  = !valid_d_r || dn_ready;
  assign up_ready = ready_d;

  // Round half up: add half a step, then keep the bits from the step upwards.
  always_comb begin
    d_sum = SUM_W'(up_ac) + SUM_W'(up_bs) + SUM_W'(park_pkg::ROUND_HALF);
    q_sum = SUM_W'(up_bc) - SUM_W'(up_as) + SUM_W'(park_pkg::ROUND_HALF);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_d_r <= 1'b0;
    end else if (ready_d) begin
      valid_d_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_d && up_valid) begin
      direct_r     <= d_sum[park_pkg::ROUND_POS +: SAMPLE_WIDTH + 1];
      quadrature_r <= q_sum[park_pkg::ROUND_POS +: SAMPLE_WIDTH + 1];
    end
  end

  assign dn_valid      = valid_d_r;
  assign dn_direct     = direct_r;
  assign dn_quadrature = quadrature_r;

`ifndef SYNTHESIS
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !valid_d_r)
    else $error("result valid straight after reset");

  // A new transaction may only load while the output stage is free or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    valid_d_r && !dn_ready |=> valid_d_r && $stable(direct_r) && $stable(quadrature_r))
    else $error("pending result overwritten");
`endif

endmodule

>>> rtl/park_transform_top.sv
`timescale 1ns / 1ps

// Channel   Direction  tdata fields (lowest bit up)
// in_*      slave      alpha_in, beta_in, phase; zero padded to whole bytes
// out_*     master     direct_out, quadrature_out; zero padded to whole bytes
//
// One transaction is taken every clock while in_tready is high.
// The result passes four register stages: table fold, interpolation, multiply, round.
// Reset clears only the stage valid bits; the data registers are not reset.
// Each stage holds its contents while the stage after it is full and stalled,
// so in_tready drops only once the whole pipeline is full.

module park_transform_top #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int PHASE_WIDTH  = 16
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             in_tvalid,
  output logic                                             in_tready,
  // alpha_in, beta_in, phase
  input  logic [((2*SAMPLE_WIDTH+PHASE_WIDTH+7)/8)*8-1:0]  in_tdata,
  output logic                                             out_tvalid,
  input  logic                                             out_tready,
  // direct_out, quadrature_out
  output logic [((2*SAMPLE_WIDTH+2+7)/8)*8-1:0]            out_tdata
);

  localparam int OUT_TDATA_W = ((2*SAMPLE_WIDTH+2+7)/8)*8;
  localparam int PROD_W      = SAMPLE_WIDTH + park_pkg::TRIG_W;

  logic signed [SAMPLE_WIDTH-1:0]        alpha, beta;
  logic        [PHASE_WIDTH-1:0]         phase;

  logic                                  trig_valid, trig_ready;
  logic signed [SAMPLE_WIDTH-1:0]        trig_alpha, trig_beta;
  logic signed [park_pkg::TRIG_W-1:0]    trig_sin, trig_cos;

  logic                                  prod_valid, prod_ready;
  logic signed [PROD_W-1:0]              prod_ac, prod_bs, prod_bc, prod_as;

  logic signed [SAMPLE_WIDTH:0]          direct, quadrature;

  assign alpha = in_tdata[0 +: SAMPLE_WIDTH];
  assign beta  = in_tdata[SAMPLE_WIDTH +: SAMPLE_WIDTH];
  assign phase = in_tdata[2*SAMPLE_WIDTH +: PHASE_WIDTH];

  park_sincos #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .PHASE_WIDTH  (PHASE_WIDTH)
  ) u_sincos (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_alpha (alpha),
    .up_beta  (beta),
    .up_phase (phase),
    .dn_valid (trig_valid),
    .dn_ready (trig_ready),
    .dn_alpha (trig_alpha),
    .dn_beta  (trig_beta),
    .dn_sin   (trig_sin),
    .dn_cos   (trig_cos)
  );

  park_mult #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (trig_valid),
    .up_ready (trig_ready),
    .up_alpha (trig_alpha),
    .up_beta  (trig_beta),
    .up_sin   (trig_sin),
    .up_cos   (trig_cos),
    .dn_valid (prod_valid),
    .dn_ready (prod_ready),
    .dn_ac    (prod_ac),
    .dn_bs    (prod_bs),
    .dn_bc    (prod_bc),
    .dn_as    (prod_as)
  );

  park_round #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_round (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (prod_valid),
    .up_ready      (prod_ready),
    .up_ac         (prod_ac),
    .up_bs         (prod_bs),
    .up_bc         (prod_bc),
    .up_as         (prod_as),
    .dn_valid      (out_tvalid),
    .dn_ready      (out_tready),
    .dn_direct     (direct),
    .dn_quadrature (quadrature)
  );

  assign out_tdata = OUT_TDATA_W'({quadrature, direct});

endmodule
